// File: rtl/core/lru_page_replacement_top_assert.svh
// -----------------------------------------------------------------------------
// LRU page replacement assertion macros
// Shared property wrappers: sampled on clk_i, quiet while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// Same-cycle property
`define LRUPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent on the next clock
`define LRUPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  `LRUPR_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: rtl/core/lrupr_pkg.sv
// -----------------------------------------------------------------------------
// LRU page replacement package
// Sizes, transaction payload types and controller/datapath handshake structs.
// -----------------------------------------------------------------------------
package lrupr_pkg;

  // Table geometry
  localparam int unsigned FRAMES    = 16;
  localparam int unsigned PAGE_BITS = 16;
  localparam int unsigned IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned CFG_W     = 5;

  // Reset value of the frame-count register
  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = CFG_W'(16);

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [STAMP_W-1:0]   stamp_t;

  // Input transaction
  typedef struct packed {
    logic        start_new;
    logic [15:0] page;
  } lrupr_req_t;

  // Result transaction
  typedef struct packed {
    logic        hit;
    logic [3:0]  frame_index;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [31:0] fault_count;
  } lrupr_rsp_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;  // capture request, bump reference counter
    logic scan;    // examine one frame
    logic place;   // resolve hit or load victim frame
  } lrupr_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic scan_last;  // current frame is the last active one
  } lrupr_sts_t;

endpackage

// File: rtl/core/lru_page_replacement_top.sv
// -----------------------------------------------------------------------------
// LRU page replacement top level
// Page reference in, hit/fault result out; least recently used frame evicted.
//
//   channel  | ports                     | handshake
//   ---------+---------------------------+--------------------------------
//   request  | req_i (lrupr_req_t)       | taken when start && !busy
//   result   | rsp_o (lrupr_rsp_t)       | valid for one cycle on done_o
//   config   | cfg_we_i, cfg_wdata_i     | written when cfg_we_i is high
//
// For each reference the scan reads one frame of the table per cycle over N frames,
// N the active frame count, and then the placement state follows.
// done_o rises the cycle after placement, when busy is already low again.
// Reset empties all frames and clears both counters; frame count resets to 16.
// The result receiver cannot stall; each result shows for exactly one cycle.
// -----------------------------------------------------------------------------
module lru_page_replacement_top
  import lrupr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  lrupr_req_t       req_i,
  output logic             done_o,
  output lrupr_rsp_t       rsp_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  lrupr_cmd_t cmd;
  lrupr_sts_t sts;

  // Sequencer
  lrupr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  // Frame table and counters
  lrupr_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule

// File: rtl/core/lrupr_ctrl.sv
// -----------------------------------------------------------------------------
// LRU page replacement controller
// Sequences accept, frame scan and placement; drives busy and result strobe.
// -----------------------------------------------------------------------------
`include "lru_page_replacement_top_assert.svh"

module lrupr_ctrl
  import lrupr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  output logic       done_o,
  output lrupr_cmd_t cmd_o,
  input  lrupr_sts_t sts_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE
  } state_e;

  state_e state_q;
  logic   done_q;

  // State and registered strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (sts_i.scan_last) state_q <= ST_PLACE;
        end
        ST_PLACE: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Commands
  assign cmd_o.accept = (state_q == ST_IDLE) && start;
  assign cmd_o.scan   = (state_q == ST_SCAN);
  assign cmd_o.place  = (state_q == ST_PLACE);

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

  `LRUPR_ASSERT_NEXT(a_accept_busy, cmd_o.accept, busy, "accept did not raise busy")
  `LRUPR_ASSERT(a_done_after_place, done_o |-> $past(cmd_o.place), "strobe without placement")
  `LRUPR_ASSERT_NEXT(a_scan_holds, cmd_o.scan && !sts_i.scan_last, cmd_o.scan,
                     "scan left early")

endmodule

// File: rtl/core/lrupr_dpath.sv
// -----------------------------------------------------------------------------
// LRU page replacement datapath
// Frame table, reference and fault counters, match scan and min-stamp search.
// -----------------------------------------------------------------------------
`include "lru_page_replacement_top_assert.svh"

module lrupr_dpath
  import lrupr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  lrupr_req_t       req_i,
  input  lrupr_cmd_t       cmd_i,
  output lrupr_sts_t       sts_o,
  output lrupr_rsp_t       rsp_o
);

  localparam stamp_t STAMP_MAX = '1;

  // Frame table; valid bits stand in for the cleared contents
  page_t              page_mem [FRAMES];
  stamp_t             stamp_mem[FRAMES];
  logic [FRAMES-1:0]  valid_q;

  logic [CFG_W-1:0] cfg_q;
  stamp_t           ref_q, ref_d, ref_base;
  stamp_t           faults_q;
  logic             found_q;

  page_t  page_q;
  stamp_t stamp_q;
  idx_t   last_q, last_d;
  idx_t   idx_q;
  idx_t   where_q;
  idx_t   min_idx_q;
  stamp_t min_stamp_q;

  logic        hit_q;
  idx_t        frame_q;
  logic        ev_valid_q;
  page_t       ev_page_q;

  idx_t   rd_addr;
  logic   rd_valid;
  page_t  rd_page;
  stamp_t rd_stamp;
  logic   match;
  logic [IDX_W+3:0] frame_wide;

  // Reference counter with clear on start_new, saturating
  assign ref_base = req_i.start_new ? '0 : ref_q;
  assign ref_d    = (ref_base == STAMP_MAX) ? ref_base : ref_base + STAMP_W'(1);

  // Last active frame index from the frame-count register
  always_comb begin
    if (cfg_q == '0) begin
      last_d = '0;
    end else if (int'(cfg_q) >= int'(FRAMES)) begin
      last_d = IDX_W'(FRAMES - 1);
    end else begin
      last_d = IDX_W'(cfg_q - CFG_W'(1));
    end
  end

  // Table read port: scan index, or victim during placement
  assign rd_addr  = cmd_i.place ? min_idx_q : idx_q;
  assign rd_valid = valid_q[rd_addr];
  assign rd_page  = page_mem[rd_addr];
  assign rd_stamp = rd_valid ? stamp_mem[rd_addr] : '0;
  assign match    = rd_valid && (rd_page == page_q);

  assign sts_o.scan_last = (idx_q == last_q);

  // Control state: config, valid bits, counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= FRAMES_IN_USE_RST;
      valid_q  <= '0;
      ref_q    <= '0;
      faults_q <= '0;
      found_q  <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (cmd_i.accept) begin
        ref_q   <= ref_d;
        found_q <= 1'b0;
        if (req_i.start_new) begin
          valid_q  <= '0;
          faults_q <= '0;
        end
      end
      if (cmd_i.scan && match) found_q <= 1'b1;
      if (cmd_i.place && !found_q) begin
        valid_q[min_idx_q] <= 1'b1;
        if (faults_q != STAMP_MAX) faults_q <= faults_q + STAMP_W'(1);
      end
    end
  end

  // Payload: request, scan registers, table contents, results
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      page_q  <= PAGE_BITS'(req_i.page);
      stamp_q <= ref_d;
      last_q  <= last_d;
      idx_q   <= '0;
    end
    // One frame per cycle: stamp matches, track the oldest stamp
    if (cmd_i.scan) begin
      idx_q <= idx_q + IDX_W'(1);
      if (match) begin
        stamp_mem[idx_q] <= stamp_q;
        if (!found_q) where_q <= idx_q;
      end
      if ((idx_q == '0) || (rd_stamp < min_stamp_q)) begin
        min_idx_q   <= idx_q;
        min_stamp_q <= rd_stamp;
      end
    end
    // Resolve: report the hit, or load the page into the victim frame
    if (cmd_i.place) begin
      if (found_q) begin
        hit_q      <= 1'b1;
        frame_q    <= where_q;
        ev_valid_q <= 1'b0;
        ev_page_q  <= '0;
      end else begin
        hit_q      <= 1'b0;
        frame_q    <= min_idx_q;
        ev_valid_q <= rd_valid;
        ev_page_q  <= rd_valid ? rd_page : '0;
        page_mem[min_idx_q]  <= page_q;
        stamp_mem[min_idx_q] <= stamp_q;
      end
    end
  end

  assign frame_wide = {4'b0, frame_q};

  assign rsp_o.hit           = hit_q;
  assign rsp_o.frame_index   = frame_wide[3:0];
  assign rsp_o.evicted_valid = ev_valid_q;
  assign rsp_o.evicted_page  = 16'(ev_page_q);
  assign rsp_o.fault_count   = faults_q;

  `LRUPR_ASSERT_NEXT(a_miss_fills, cmd_i.place && !found_q, valid_q != '0,
                     "miss left the table empty")
  `LRUPR_ASSERT_NEXT(a_scan_no_fault, cmd_i.scan, $stable(faults_q),
                     "fault count moved during scan")
  `LRUPR_ASSERT_NEXT(a_hit_keeps_valid, cmd_i.place && found_q, $stable(valid_q),
                     "hit changed frame occupancy")

endmodule

// File: tb/lru_page_replacement_checker.sv
// -----------------------------------------------------------------------------
// LRU page replacement checker
// Watches the request, config and result channels of the page replacement
// block, keeps its own copy of the frame table and compares every result
// transaction with the predicted one, field by field.
// -----------------------------------------------------------------------------
module lru_page_replacement_checker
  import lrupr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  lrupr_req_t       req_i,
  input  logic             done_o,
  input  lrupr_rsp_t       rsp_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output int               fail_count_o,
  output int               pending_o
);

  // Shadow frame table
  logic [15:0]      resident_page [FRAMES];
  logic             resident_valid[FRAMES];
  logic [31:0]      use_stamp     [FRAMES];
  logic [31:0]      ref_count;
  logic [31:0]      fault_total;
  logic [CFG_W-1:0] frames_cfg;

  lrupr_rsp_t predicted_rsp_q[$];
  int         mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic clear_frames();
    for (int f = 0; f < FRAMES; f++) begin
      resident_page[f]  = '0;
      resident_valid[f] = 1'b0;
      use_stamp[f]      = '0;
    end
    ref_count   = '0;
    fault_total = '0;
  endtask

  // Look the page up, update the shadow table and return the expected result
  task automatic lookup_page(input lrupr_req_t req, output lrupr_rsp_t rsp);
    int          active;
    int          where;
    bit          found;
    logic [31:0] stamp;
    active = 0;
    where  = 0;
    found  = 1'b0;
    rsp    = '0;
    if (req.start_new) clear_frames();
    active = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg);
    // saturating reference counter doubles as stamp source
    if (ref_count != '1) ref_count = ref_count + 1;
    stamp = ref_count;
    // every active matching frame is refreshed, the lowest one is reported
    for (int f = 0; f < active; f++) begin
      if (resident_valid[f] && resident_page[f] == req.page) begin
        if (!found) where = f;
        found        = 1'b1;
        use_stamp[f] = stamp;
      end
    end
    if (!found) begin
      where = 0;
      for (int f = 1; f < active; f++) begin
        if (use_stamp[f] < use_stamp[where]) where = f;
      end
      if (resident_valid[where]) begin
        rsp.evicted_valid = 1'b1;
        rsp.evicted_page  = resident_page[where];
      end
      resident_page[where]  = req.page;
      resident_valid[where] = 1'b1;
      use_stamp[where]      = stamp;
      if (fault_total != '1) fault_total = fault_total + 1;
    end
    rsp.hit         = found;
    rsp.frame_index = where[3:0];
    rsp.fault_count = fault_total;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Channel monitor: results checked before new requests are queued
  always @(posedge clk_i or negedge rst_ni) begin
    lrupr_rsp_t want;
    want = '0;
    if (!rst_ni) begin
      clear_frames();
      frames_cfg = FRAMES_IN_USE_RST;
      predicted_rsp_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) frames_cfg = cfg_wdata_i;
      if (done_o) begin
        if (predicted_rsp_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual 0x%0h", $time, rsp_i);
        end else begin
          want = predicted_rsp_q.pop_front();
          check_field("hit", want.hit, rsp_i.hit);
          check_field("frame_index", want.frame_index, rsp_i.frame_index);
          check_field("evicted_valid", want.evicted_valid, rsp_i.evicted_valid);
          check_field("evicted_page", want.evicted_page, rsp_i.evicted_page);
          check_field("fault_count", want.fault_count, rsp_i.fault_count);
        end
      end
      if (start && !busy) begin
        lookup_page(req_i, want);
        predicted_rsp_q.push_back(want);
      end
      pending_o <= predicted_rsp_q.size();
    end
  end

endmodule

// File: tb/lru_page_replacement_top_tb.sv
// -----------------------------------------------------------------------------
// LRU page replacement testbench
// Drives page references and frame-count writes into the block: a directed
// pass over fill, hit, eviction, frame-count clamping and duplicate pages,
// then random working-set traffic with bursty idling. The checker predicts
// and compares; this module makes stimulus and reports the verdict.
// -----------------------------------------------------------------------------
module lru_page_replacement_top_tb;
  import lrupr_pkg::*;

  localparam int RANDOM_PHASES   = 12;
  localparam int REFS_PER_PHASE  = 37;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  lrupr_req_t       req_i       = '0;
  logic             done_o;
  lrupr_rsp_t       rsp_o;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = FRAMES_IN_USE_RST;
  int               fail_count;
  int               pending;
  int               active_frames = FRAMES;

  lru_page_replacement_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  lru_page_replacement_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .done_o       (done_o),
    .rsp_i        (rsp_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // One reference transaction; start stays high for a back-to-back follower
  task automatic send_ref(input logic start_new, input logic [15:0] page);
    start <= 1'b1;
    req_i <= '{start_new: start_new, page: page};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Wait until every predicted result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] value);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    active_frames = (value == 0) ? 1 : (value > FRAMES) ? FRAMES : int'(value);
  endtask

  // Random phase: mostly a looping working set sized around the frame count
  task automatic random_phase(input bit allow_idle);
    logic [15:0] pool_base;
    int          pool_size;
    bit          idle_on;
    logic [15:0] page;
    pool_base = 16'($urandom);
    pool_size = active_frames + $urandom_range(0, 4);
    idle_on   = allow_idle && ($urandom_range(0, 3) != 0);
    page      = '0;
    for (int n = 0; n < REFS_PER_PHASE; n++) begin
      if ($urandom_range(0, 3) == 0) page = 16'($urandom);
      else page = pool_base + 16'($urandom_range(0, pool_size - 1));
      send_ref($urandom_range(0, 31) == 0, page);
      if (idle_on && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 17));
      if (allow_idle && $urandom_range(0, 99) == 0) drain();
    end
  endtask

  initial begin
    logic [CFG_W-1:0] frames_value;
    frames_value = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default 16 frames: fill, extreme pages, hit
    send_ref(1'b1, 16'h0000);
    send_ref(1'b0, 16'hFFFF);
    send_ref(1'b0, 16'h0000);
    send_ref(1'b0, 16'hAAAA);
    send_ref(1'b0, 16'h5555);

    // Zero frames acts as one: every miss evicts frame 0
    write_frames(5'd0);
    send_ref(1'b0, 16'h0001);
    send_ref(1'b0, 16'h0001);
    send_ref(1'b0, 16'hAAAA);

    // Above the table size acts as 16; AAAA now resident twice
    write_frames(5'd31);
    send_ref(1'b0, 16'hAAAA);
    send_ref(1'b0, 16'hFFFF);

    // Two frames: least recently used goes, then a start clears all
    write_frames(5'd2);
    send_ref(1'b0, 16'h0003);
    send_ref(1'b0, 16'h0004);
    send_ref(1'b0, 16'h0003);
    send_ref(1'b0, 16'h0005);
    send_ref(1'b1, 16'h0007);

    // Seventeen clamps to 16; hold-off with nothing outstanding
    write_frames(5'd17);
    send_ref(1'b0, 16'h0007);
    send_ref(1'b0, 16'h8000);
    drain();
    send_ref(1'b0, 16'h0007);

    // Random traffic; the last phase runs without idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) frames_value = 5'd16;
      else if (p == 1) frames_value = 5'd1;
      else if ($urandom_range(0, 4) == 0) frames_value = 5'($urandom_range(0, 31));
      else frames_value = 5'($urandom_range(1, 16));
      write_frames(frames_value);
      random_phase(p != RANDOM_PHASES - 1);
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/lrupr_pkg.sv
rtl/core/lrupr_ctrl.sv
rtl/core/lrupr_dpath.sv
rtl/core/lru_page_replacement_top.sv
tb/lru_page_replacement_checker.sv
tb/lru_page_replacement_top_tb.sv
